FILE: sv/rau_pkg.sv
// rau_pkg: shared widths, beat types and sign-magnitude helpers for the
// rational arithmetic unit. No dependencies.
`default_nettype none
package rau_pkg;

	localparam int W     = 16;
	localparam int NUMW  = 2 * W + 1;
	localparam int DENW  = 2 * W;
	localparam int RNW   = 33;
	localparam int RDW   = 31;
	localparam int XNW   = (NUMW > RNW) ? NUMW : RNW;
	localparam int XDW   = (DENW > RDW) ? DENW : RDW;
	localparam int CW    = $clog2(NUMW);
	localparam int KW    = $clog2(NUMW + 1);
	localparam int QDEPTH = 2;
	localparam int QAW   = 1;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	typedef struct packed {
		logic [1:0]          kind;
		logic signed [W-1:0] a_num;
		logic signed [W-1:0] a_den;
		logic signed [W-1:0] b_num;
		logic signed [W-1:0] b_den;
	} req_t;

	typedef struct packed {
		logic signed [RNW-1:0] result_num;
		logic [RDW-1:0]        result_den;
		logic                  div_by_zero;
	} rsp_t;

	typedef struct packed {
		logic         neg;
		logic [W-1:0] mag;
	} smag_t;

	typedef struct packed {
		logic           neg;
		logic [DENW-1:0] mag;
	} prod_t;

	// one queue entry: sign of result, magnitudes, undefined-result flag
	typedef struct packed {
		logic            neg;
		logic            flag;
		logic [NUMW-1:0] nmag;
		logic [DENW-1:0] dmag;
	} job_t;

	function automatic smag_t to_smag(logic [W-1:0] raw);
		smag_t r;
		r.neg = raw[W-1];
		r.mag = raw[W-1] ? (~raw + W'(1)) : raw;
		return r;
	endfunction

	function automatic prod_t mul_sm(smag_t x, smag_t y);
		prod_t r;
		r.neg = x.neg ^ y.neg;
		r.mag = {{W{1'b0}}, x.mag} * {{W{1'b0}}, y.mag};
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: sv/rau_front.sv
// rau_front: accepts request beats, picks operands, forms exact products
// and their sum for add/sub. Depends on rau_pkg.
`default_nettype none
module rau_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rau_pkg::req_t req,
	output logic               push,
	output rau_pkg::job_t      push_data,
	input  wire logic          full
);
	rau_pkg::smag_t an, ad, bn, bd;
	rau_pkg::smag_t m1x_s1, m1y_s1, m2x_s1, m2y_s1, dx_s1, dy_s1;
	logic use_sum_s1, flag_s1, v_s1;
	rau_pkg::prod_t p1_s2, p2_s2, pd_s2;
	logic use_sum_s2, flag_s2, v_s2;
	logic mv1, mv2;
	logic [rau_pkg::NUMW-1:0] e1, e2;

	assign an = rau_pkg::to_smag(req.a_num);
	assign ad = rau_pkg::to_smag(req.a_den);
	assign bn = rau_pkg::to_smag(req.b_num);
	assign bd = rau_pkg::to_smag(req.b_den);

	assign mv2 = v_s2 && !full;
	assign mv1 = v_s1 && (!v_s2 || mv2);
	assign req_stall = v_s1 && !mv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (mv1 || !v_s1) v_s1 <= req_valid;
			if (mv2 || !v_s2) v_s2 <= mv1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && (!v_s1 || mv1)) begin
			dx_s1 <= ad;
			m1x_s1 <= an;
			flag_s1 <= (ad.mag == '0) || (bd.mag == '0) ||
				((req.kind == rau_pkg::OP_DIV) && (bn.mag == '0));
			m2y_s1 <= ad;
			case (req.kind)
				rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
					use_sum_s1 <= 1'b1;
					m1y_s1 <= bd;
					m2x_s1 <= '{neg: bn.neg ^ (req.kind == rau_pkg::OP_SUB), mag: bn.mag};
					dy_s1 <= bd;
				end
				rau_pkg::OP_MUL: begin
					use_sum_s1 <= 1'b0;
					m1y_s1 <= bn;
					m2x_s1 <= bn;
					dy_s1 <= bd;
				end
				default: begin
					use_sum_s1 <= 1'b0;
					m1y_s1 <= bd;
					m2x_s1 <= bn;
					dy_s1 <= bn;
				end
			endcase
		end
		if (mv1) begin
			p1_s2 <= rau_pkg::mul_sm(m1x_s1, m1y_s1);
			p2_s2 <= rau_pkg::mul_sm(m2x_s1, m2y_s1);
			pd_s2 <= rau_pkg::mul_sm(dx_s1, dy_s1);
			use_sum_s2 <= use_sum_s1;
			flag_s2 <= flag_s1;
		end
	end

	assign e1 = {1'b0, p1_s2.mag};
	assign e2 = {1'b0, p2_s2.mag};

	always_comb begin
		push = mv2;
		push_data.flag = flag_s2;
		push_data.dmag = pd_s2.mag;
		push_data.nmag = e1;
		push_data.neg = p1_s2.neg ^ pd_s2.neg;
		if (use_sum_s2) begin
			if (p1_s2.neg == p2_s2.neg) begin
				push_data.nmag = e1 + e2;
			end else if (e1 >= e2) begin
				push_data.nmag = e1 - e2;
			end else begin
				push_data.nmag = e2 - e1;
				push_data.neg = p2_s2.neg ^ pd_s2.neg;
			end
		end
	end
endmodule
`default_nettype wire

FILE: sv/rau_queue.sv
// rau_queue: short job queue between front and back.
// Depends on rau_pkg.
`default_nettype none
module rau_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rau_pkg::job_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               avail,
	output rau_pkg::job_t      pop_data
);
	rau_pkg::job_t mem_q [rau_pkg::QDEPTH];
	logic [rau_pkg::QAW-1:0] wp_q, rp_q;
	logic [rau_pkg::QAW:0] cnt_q;

	assign full = cnt_q == (rau_pkg::QAW+1)'(rau_pkg::QDEPTH);
	assign avail = cnt_q != '0;
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (rau_pkg::QAW+1)'(push) - (rau_pkg::QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end
endmodule
`default_nettype wire

FILE: sv/rau_back.sv
// rau_back: binary gcd and a shared restoring divider reduce each job;
// holds the response register. Depends on rau_pkg.
`default_nettype none
module rau_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          avail,
	input  wire rau_pkg::job_t job,
	output logic               pop,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rau_pkg::rsp_t      rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_GCD  = 3'd1;
	localparam logic [2:0] ST_DIVN = 3'd2;
	localparam logic [2:0] ST_DIVD = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic neg_q, flag_q, zero_q, rsp_valid_q;
	logic [rau_pkg::NUMW-1:0] u_q, v_q, quo_q, resn_q;
	logic [rau_pkg::DENW-1:0] dmag_q, g_q, resd_q;
	logic [rau_pkg::DENW:0] rem_q, rsh, rnext;
	logic [rau_pkg::KW-1:0] k_q;
	logic [rau_pkg::CW-1:0] cnt_q;
	logic ge;
	logic [rau_pkg::NUMW-1:0] qnext, gsh;
	logic [rau_pkg::XNW:0] nx;
	logic [rau_pkg::XDW-1:0] dx;

	assign pop = (state_q == ST_IDLE) && avail;
	assign rsh = {rem_q[rau_pkg::DENW-1:0], quo_q[rau_pkg::NUMW-1]};
	assign ge = rsh >= {1'b0, g_q};
	assign rnext = ge ? (rsh - {1'b0, g_q}) : rsh;
	assign qnext = {quo_q[rau_pkg::NUMW-2:0], ge};
	assign gsh = u_q << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (avail) begin
					state_q <= (job.flag || job.nmag == '0) ? ST_DONE : ST_GCD;
				end
				ST_GCD: if (u_q == v_q) state_q <= ST_DIVN;
				ST_DIVN: if (cnt_q == rau_pkg::CW'(rau_pkg::NUMW - 1)) state_q <= ST_DIVD;
				ST_DIVD: if (cnt_q == rau_pkg::CW'(rau_pkg::NUMW - 1)) state_q <= ST_DONE;
				ST_DONE: if (!rsp_valid_q || !rsp_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				neg_q <= job.neg;
				flag_q <= job.flag;
				zero_q <= job.flag || job.nmag == '0;
				u_q <= job.nmag;
				v_q <= {1'b0, job.dmag};
				quo_q <= job.nmag;
				dmag_q <= job.dmag;
				k_q <= '0;
			end
			ST_GCD: begin
				rem_q <= '0;
				cnt_q <= '0;
				if (u_q == v_q) begin
					g_q <= gsh[rau_pkg::DENW-1:0];
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q > v_q) begin
					u_q <= u_q - v_q;
				end else begin
					v_q <= v_q - u_q;
				end
			end
			ST_DIVN, ST_DIVD: begin
				if (cnt_q == rau_pkg::CW'(rau_pkg::NUMW - 1)) begin
					rem_q <= '0;
					cnt_q <= '0;
					if (state_q == ST_DIVN) begin
						resn_q <= qnext;
						quo_q <= {1'b0, dmag_q};
					end else begin
						resd_q <= qnext[rau_pkg::DENW-1:0];
						quo_q <= qnext;
					end
				end else begin
					rem_q <= rnext;
					quo_q <= qnext;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp.div_by_zero <= flag_q;
			if (zero_q) begin
				rsp.result_num <= '0;
				rsp.result_den <= rau_pkg::RDW'(1);
			end else begin
				rsp.result_num <= nx[rau_pkg::RNW-1:0];
				rsp.result_den <= dx[rau_pkg::RDW-1:0];
			end
		end
	end

	always_comb begin
		nx = (rau_pkg::XNW+1)'(resn_q);
		if (neg_q) nx = -nx;
		dx = rau_pkg::XDW'(resd_q);
	end

	assign rsp_valid = rsp_valid_q;
endmodule
`default_nettype wire

FILE: sv/rational_arithmetic_unit_core.sv
// rational_arithmetic_unit_core: top level, front / queue / back.
// Depends on rau_pkg, rau_front, rau_queue, rau_back.
//
//  channel  beat   handshake            direction
//  req      req_t  req_valid/req_stall  in
//  rsp      rsp_t  rsp_valid/rsp_stall  out
//
// Front: two register stages (operand pick, products), then a 2-deep queue.
// Back: binary gcd, one subtract or shift a cycle, then two 33-step
// restoring divisions. Flagged or zero results skip straight to the
// response register. Reset clears control only. Either side may stall
// independently.
`default_nettype none
module rational_arithmetic_unit_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire rau_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output rau_pkg::rsp_t      rsp
);
	logic push, full, pop, avail;
	rau_pkg::job_t push_data, pop_data;

	rau_front u_front (
		.clk, .arst_n, .req_valid, .req_stall, .req,
		.push, .push_data, .full
	);

	rau_queue u_queue (
		.clk, .arst_n, .push, .push_data, .full,
		.pop, .avail, .pop_data
	);

	rau_back u_back (
		.clk, .arst_n, .avail, .job(pop_data), .pop,
		.rsp_valid, .rsp_stall, .rsp
	);
endmodule
`default_nettype wire

FILE: sv/rau_checker.sv
// rau_checker: port-level assertions for the top level, with bind.
// Depends on rau_pkg and rational_arithmetic_unit_core.
`default_nettype none
module rau_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_stall,
	input wire rau_pkg::rsp_t rsp
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp beat dropped under stall");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.div_by_zero |-> rsp.result_num == '0 && rsp.result_den == 1)
		else $error("flagged result not 0/1");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.result_num == '0 |-> rsp.result_den == 1)
		else $error("zero result not over 1");

	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.result_den != '0)
		else $error("zero denominator");
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
	.clk, .arst_n, .rsp_valid, .rsp_stall, .rsp
);
`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking bench for rational_arithmetic_unit_core, predicting each
// reduced fraction from the operands. Depends on rau_pkg and the core RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	localparam int WATCHDOG = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	rau_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rau_pkg::rsp_t rsp;

	rau_pkg::rsp_t fraction_q[$];
	int mismatches;
	int idle_cycles;
	bit calm;

	rational_arithmetic_unit_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [63:0] mag_of(logic [15:0] raw);
		return raw[15] ? 64'(17'h10000 - {1'b0, raw}) : 64'(raw);
	endfunction

	function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic rau_pkg::rsp_t reduce_fraction(rau_pkg::req_t r);
		rau_pkg::rsp_t o;
		logic [63:0] an, ad, bn, bd, p, q, nm, dm, g, tm;
		logic sa, sad, sb, sbd, sp, sq, nneg, dneg, tn;
		o = '0;
		o.result_den = 31'd1;
		an = mag_of(r.a_num); sa = r.a_num[15];
		ad = mag_of(r.a_den); sad = r.a_den[15];
		bn = mag_of(r.b_num); sb = r.b_num[15];
		bd = mag_of(r.b_den); sbd = r.b_den[15];
		if (ad == 0 || bd == 0) begin
			o.div_by_zero = 1'b1;
			return o;
		end
		if (r.kind == rau_pkg::OP_ADD || r.kind == rau_pkg::OP_SUB) begin
			if (r.kind == rau_pkg::OP_SUB)
				sb = ~sb;
			p = an * bd; sp = sa ^ sbd;
			q = bn * ad; sq = sb ^ sad;
			if (sp == sq) begin
				nm = p + q; nneg = sp;
			end else if (p >= q) begin
				nm = p - q; nneg = sp;
			end else begin
				nm = q - p; nneg = sq;
			end
		end else begin
			if (r.kind == rau_pkg::OP_DIV) begin
				if (bn == 0) begin
					o.div_by_zero = 1'b1;
					return o;
				end
				tm = bn; bn = bd; bd = tm;
				tn = sb; sb = sbd; sbd = tn;
			end
			nm = an * bn; nneg = sa ^ sb;
		end
		dm = ad * bd; dneg = sad ^ sbd;
		if (nm == 0)
			return o;
		g = gcd64(nm, dm);
		nm = nm / g;
		o.result_num = (nneg != dneg) ? 33'(-nm) : 33'(nm);
		o.result_den = 31'(dm / g);
		return o;
	endfunction

	task automatic send_fraction(logic [1:0] kind, logic [15:0] an, logic [15:0] ad,
			logic [15:0] bn, logic [15:0] bd);
		rau_pkg::req_t r;
		r.kind = kind; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		fraction_q.push_back(reduce_fraction(r));
	endtask

	function automatic logic [15:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] rand_den();
		logic [15:0] d;
		d = rand_operand();
		if ($urandom_range(0, 30) != 0 && d == 0)
			d = 16'd1;
		return d;
	endfunction

	task automatic test_directed();
		logic [1:0] ops[4];
		ops = '{rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_DIV};
		foreach (ops[i]) begin
			send_fraction(ops[i], 16'h8000, 16'h8000, 16'h8000, 16'h8000);
			send_fraction(ops[i], 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
			send_fraction(ops[i], 16'd0, 16'd5, 16'd3, 16'hfff9);
			send_fraction(ops[i], 16'd6, 16'd0, 16'd3, 16'd4);
			send_fraction(ops[i], 16'hfffd, 16'd4, 16'd0, 16'hffff);
		end
		send_fraction(rau_pkg::OP_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
		send_fraction(rau_pkg::OP_ADD, 16'd1, 16'd3, 16'd1, 16'hffff);
		send_fraction(rau_pkg::OP_MUL, 16'h7fff, 16'h0001, 16'h7fff, 16'h0001);
	endtask

	task automatic test_random(int n);
		repeat (n)
			send_fraction(2'($urandom), rand_operand(), rand_den(), rand_operand(),
				rand_den());
	endtask

	// response side: stall bursts and compare against oldest prediction
	initial begin
		rau_pkg::rsp_t want;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (fraction_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat %h", rsp);
				end else begin
					want = fraction_q.pop_front();
					if (rsp.result_num !== want.result_num
							|| rsp.result_den !== want.result_den
							|| rsp.div_by_zero !== want.div_by_zero) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %0d/%0d f%b got %0d/%0d f%b",
								want.result_num, want.result_den, want.div_by_zero,
								rsp.result_num, rsp.result_den, rsp.div_by_zero);
					end
				end
			end
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(negedge clk);
			end
			rsp_stall <= 1'b0;
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		mismatches = 0;
		calm = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random(400);
		calm = 1'b1;
		test_random(100);
		@(negedge clk);
		req_valid <= 1'b0;
		while (fraction_q.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && fraction_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
sv/rau_pkg.sv
sv/rau_front.sv
sv/rau_queue.sv
sv/rau_back.sv
sv/rational_arithmetic_unit_core.sv
sv/rau_checker.sv
verif/tb.sv
